// ===== rtl/tcw_pkg.sv =====
// shared types, constants and helpers of the text console writer
package tcw_pkg;

	// screen geometry
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS);
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int CELL_W     = 16;

	// cell contents
	localparam logic [7:0] BLANK_CHAR   = 8'h20;
	localparam logic [7:0] BLANK_COLOR  = 8'h0F;
	localparam logic [7:0] NEWLINE_CHAR = 8'd10;

	// action codes
	localparam logic [1:0] ACT_PUT  = 2'd0;
	localparam logic [1:0] ACT_FILL = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	// command beat
	typedef struct packed {
		logic [1:0] action;
		logic [7:0] char_code;
		logic [7:0] color;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} tcw_cmd_t;

	// result beat
	typedef struct packed {
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
		logic       scrolled;
		logic [7:0] cell_char;
		logic [7:0] cell_color;
	} tcw_res_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WALK
	} tcw_state_t;

	// linear store address of a physical row and a column
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		cell_addr = ADDR_W'(int'(r) * COLUMNS + int'(c));
	endfunction

endpackage

// ===== rtl/tcw_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== rtl/text_console_writer.sv =====
// text console writer top level: screen store, cursor and command sequencer
//
// A command beat is taken when start is high and busy is low. Every command
// gives exactly one result beat, shown on res for one cycle with done high;
// the receiver cannot stall it and busy stays low once done is shown.
// A put without scroll, an undefined action and a read out of range answer
// straight from the idle state; a read of a cell first passes through the
// registered ram read and the read state. A put that scrolls blanks the
// bottom row one cell per cycle through the single ram write port, and a
// fill writes every cell, one per cycle; both run in the walk state.
// The screen is kept as a ring of rows: a scroll only moves the top-row
// pointer and blanks the row that falls to the bottom, so no row is copied.
// After reset the block sweeps the whole store with space and colour 0x0F,
// holding busy high while the sweep runs; no result beat is given
// for that sweep. The cursor starts at row 0, column 0.
module text_console_writer
	import tcw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  tcw_cmd_t cmd,
	output logic     done,
	output tcw_res_t res
);

	tcw_state_t        state_q, state_d;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ROW_W-1:0]  top_q;
	logic [ADDR_W-1:0] walk_addr_q, walk_end_q;
	logic [7:0]        walk_color_q;
	logic              walk_report_q;
	logic              done_q;
	logic              done_d;
	tcw_res_t          res_q;
	tcw_res_t          res_d;

	logic              accept;
	logic              walk_last;

	// ram ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;

	// put path
	logic              is_nl;
	logic [COL_W:0]    col_inc;
	logic              wrap;
	logic              next_line;
	logic [ROW_W:0]    row_inc;
	logic              put_scroll;
	logic [COL_W-1:0]  put_col;
	logic [ROW_W-1:0]  put_row;
	logic [ROW_W-1:0]  top_inc;
	logic [ROW_W-1:0]  cur_phys;

	// read path
	logic              rd_in_range;
	logic [ROW_W:0]    rd_sum;
	logic [ROW_W-1:0]  rd_phys;

	assign accept    = start && (state_q == ST_IDLE);
	assign walk_last = (walk_addr_q == walk_end_q);

	// cursor advance for a put
	always_comb begin
		is_nl      = (cmd.char_code == NEWLINE_CHAR);
		col_inc    = {1'b0, col_q} + (COL_W+1)'(1);
		wrap       = !is_nl && (col_inc == (COL_W+1)'(COLUMNS));
		next_line  = is_nl || wrap;
		row_inc    = {1'b0, row_q} + (ROW_W+1)'(1);
		put_scroll = next_line && (row_inc == (ROW_W+1)'(ROWS));
		put_col    = next_line ? '0 : col_inc[COL_W-1:0];
		if (put_scroll) begin
			put_row = ROW_W'(ROWS - 1);
		end else if (next_line) begin
			put_row = row_inc[ROW_W-1:0];
		end else begin
			put_row = row_q;
		end
		top_inc = (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + ROW_W'(1);
		// physical row of the cursor in the row ring
		if ({1'b0, row_q} + {1'b0, top_q} >= (ROW_W+1)'(ROWS)) begin
			cur_phys = row_q + top_q - ROW_W'(ROWS);
		end else begin
			cur_phys = row_q + top_q;
		end
	end

	// physical location of a read
	always_comb begin
		rd_in_range = (int'(cmd.read_row) < ROWS) && (int'(cmd.read_col) < COLUMNS);
		rd_sum      = (ROW_W+1)'(cmd.read_row) + {1'b0, top_q};
		if (rd_sum >= (ROW_W+1)'(ROWS)) begin
			rd_phys = ROW_W'(rd_sum - (ROW_W+1)'(ROWS));
		end else begin
			rd_phys = rd_sum[ROW_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd.action)
						ACT_PUT:  if (put_scroll) state_d = ST_WALK;
						ACT_FILL: state_d = ST_WALK;
						ACT_READ: if (rd_in_range) state_d = ST_READ;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ: state_d = ST_IDLE;
			ST_WALK: if (walk_last) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// ram control and handshake outputs
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = walk_addr_q;
		ram_wdata = {walk_color_q, BLANK_CHAR};
		ram_raddr = cell_addr(rd_phys, cmd.read_col[COL_W-1:0]);
		busy      = 1'b1;
		done_d    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (accept && (cmd.action == ACT_PUT) && !is_nl) begin
					ram_we    = 1'b1;
					ram_waddr = cell_addr(cur_phys, col_q);
					ram_wdata = {cmd.color, cmd.char_code};
				end
				if (accept) begin
					case (cmd.action)
						ACT_PUT:  done_d = !put_scroll;
						ACT_FILL: done_d = 1'b0;
						ACT_READ: done_d = !rd_in_range;
						default:  done_d = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				ram_we = 1'b0;
				done_d = 1'b1;
			end
			ST_WALK: begin
				ram_we = 1'b1;
				done_d = walk_last && walk_report_q;
			end
			default: ram_we = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_WALK;
			col_q         <= '0;
			row_q         <= '0;
			top_q         <= '0;
			walk_addr_q   <= '0;
			walk_end_q    <= ADDR_W'(CELL_COUNT - 1);
			walk_color_q  <= BLANK_COLOR;
			walk_report_q <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd.action)
							ACT_PUT: begin
								col_q <= put_col;
								row_q <= put_row;
								if (put_scroll) begin
									// old top row becomes the blank bottom row
									top_q         <= top_inc;
									walk_addr_q   <= cell_addr(top_q, '0);
									walk_end_q    <= cell_addr(top_q, COL_W'(COLUMNS - 1));
									walk_color_q  <= BLANK_COLOR;
									walk_report_q <= 1'b1;
								end
							end
							ACT_FILL: begin
								col_q         <= '0;
								row_q         <= '0;
								top_q         <= '0;
								walk_addr_q   <= '0;
								walk_end_q    <= ADDR_W'(CELL_COUNT - 1);
								walk_color_q  <= cmd.color;
								walk_report_q <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				ST_WALK: begin
					walk_addr_q <= walk_addr_q + ADDR_W'(1);
				end
				default: ;
			endcase
		end
	end

	// next result beat
	always_comb begin
		res_d = res_q;
		if (accept) begin
			res_d            = '0;
			res_d.cursor_col = 7'(col_q);
			res_d.cursor_row = 5'(row_q);
			case (cmd.action)
				ACT_PUT: begin
					res_d.cursor_col = 7'(put_col);
					res_d.cursor_row = 5'(put_row);
					res_d.scrolled   = put_scroll;
				end
				ACT_FILL: begin
					res_d.cursor_col = '0;
					res_d.cursor_row = '0;
				end
				default: res_d.scrolled = 1'b0;
			endcase
		end else if (state_q == ST_READ) begin
			res_d.cell_char  = ram_rdata[7:0];
			res_d.cell_color = ram_rdata[15:8];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT)
	) u_screen (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== rtl/tcw_checker.sv =====
// port-level checks of the text console writer, bound to the top level
module tcw_checker
	import tcw_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input tcw_cmd_t cmd,
	input logic     done,
	input tcw_res_t res
);

	// a result beat is only shown once the work is over
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// an accepted command either answers at once or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted command neither answered nor in progress");

	// reported cursor always lies on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((int'(res.cursor_row) < ROWS) && (int'(res.cursor_col) < COLUMNS)))
		else $error("cursor off screen");

	// a scroll leaves the cursor at the start of the last row
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.scrolled) |->
			((int'(res.cursor_row) == ROWS - 1) && (res.cursor_col == '0)))
		else $error("cursor not on last row after scroll");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

// ===== bench/testbench.sv =====
// self-checking testbench for the text console writer: directed table, then random commands
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tcw_pkg::*;

	// action code the block leaves undefined
	localparam logic [1:0] ACT_NONE = 2'd3;

	localparam int RANDOM_ITEMS = 280;
	localparam int DRAIN_EVERY  = 64;
	localparam int TAIL_CYCLES  = 100;
	// fill plus reset sweep plus the longest sender gap, several times over
	localparam int STALL_LIMIT  = 20000;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	tcw_cmd_t cmd;
	logic     done;
	tcw_res_t res;

	text_console_writer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.res    (res)
	);

	// shadow copy of the screen and cursor
	logic [15:0] shadow_screen [CELL_COUNT];
	int          cur_col;
	int          cur_row;

	tcw_res_t    pending_res [$];
	int          errors;
	int          idle_cycles;
	int          burst_left;

	// directed table; a row with typed set carries its result read straight off the spec
	typedef struct {
		logic [1:0]  act;
		logic [7:0]  ch;
		logic [7:0]  colr;
		logic [4:0]  rrow;
		logic [6:0]  rcol;
		int          reps;
		bit          typed;
		logic [6:0]  w_col;
		logic [4:0]  w_row;
		logic        w_scr;
		logic [7:0]  w_char;
		logic [7:0]  w_color;
	} plan_row_t;

	localparam int PLAN_ROWS = 25;

	plan_row_t plan [PLAN_ROWS] = '{
		// blank screen after reset, corners
		'{ACT_READ, 8'h00, 8'h00, 5'd0,  7'd0,   1,  1, 7'd0, 5'd0,  1'b0, 8'h20, 8'h0F},
		'{ACT_READ, 8'h00, 8'h00, 5'd24, 7'd79,  1,  1, 7'd0, 5'd0,  1'b0, 8'h20, 8'h0F},
		// reads off the screen return nothing
		'{ACT_READ, 8'h00, 8'h00, 5'd25, 7'd0,   1,  1, 7'd0, 5'd0,  1'b0, 8'h00, 8'h00},
		'{ACT_READ, 8'hFF, 8'hFF, 5'd31, 7'd127, 1,  1, 7'd0, 5'd0,  1'b0, 8'h00, 8'h00},
		'{ACT_READ, 8'h00, 8'h00, 5'd0,  7'd80,  1,  1, 7'd0, 5'd0,  1'b0, 8'h00, 8'h00},
		// undefined action changes nothing
		'{ACT_NONE, 8'hFF, 8'hFF, 5'd31, 7'd127, 1,  1, 7'd0, 5'd0,  1'b0, 8'h00, 8'h00},
		// puts at the extremes of char and colour
		'{ACT_PUT,  8'h41, 8'h00, 5'd0,  7'd0,   1,  1, 7'd1, 5'd0,  1'b0, 8'h00, 8'h00},
		'{ACT_PUT,  8'hFF, 8'hFF, 5'd31, 7'd127, 1,  1, 7'd2, 5'd0,  1'b0, 8'h00, 8'h00},
		'{ACT_PUT,  8'h00, 8'h80, 5'd0,  7'd0,   1,  1, 7'd3, 5'd0,  1'b0, 8'h00, 8'h00},
		'{ACT_READ, 8'h00, 8'h00, 5'd0,  7'd1,   1,  1, 7'd3, 5'd0,  1'b0, 8'hFF, 8'hFF},
		'{ACT_READ, 8'h00, 8'h00, 5'd0,  7'd2,   1,  1, 7'd3, 5'd0,  1'b0, 8'h00, 8'h80},
		// newline moves the cursor and writes nothing
		'{ACT_PUT,  8'd10, 8'h0F, 5'd0,  7'd0,   1,  1, 7'd0, 5'd1,  1'b0, 8'h00, 8'h00},
		'{ACT_READ, 8'h00, 8'h00, 5'd0,  7'd3,   1,  1, 7'd0, 5'd1,  1'b0, 8'h20, 8'h0F},
		// fill homes the cursor
		'{ACT_FILL, 8'h00, 8'hFF, 5'd0,  7'd0,   1,  1, 7'd0, 5'd0,  1'b0, 8'h00, 8'h00},
		'{ACT_READ, 8'h00, 8'h00, 5'd12, 7'd40,  1,  1, 7'd0, 5'd0,  1'b0, 8'h20, 8'hFF},
		// newline on the last row scrolls; the new bottom row is blank with 0x0F
		'{ACT_PUT,  8'd10, 8'h00, 5'd0,  7'd0,   24, 0, 7'd0, 5'd0,  1'b0, 8'h00, 8'h00},
		'{ACT_PUT,  8'd10, 8'h00, 5'd0,  7'd0,   1,  1, 7'd0, 5'd24, 1'b1, 8'h00, 8'h00},
		'{ACT_READ, 8'h00, 8'h00, 5'd24, 7'd5,   1,  1, 7'd0, 5'd24, 1'b0, 8'h20, 8'h0F},
		'{ACT_READ, 8'h00, 8'h00, 5'd23, 7'd5,   1,  1, 7'd0, 5'd24, 1'b0, 8'h20, 8'hFF},
		// wrapping put on the last row scrolls too
		'{ACT_PUT,  8'h5A, 8'h1E, 5'd0,  7'd0,   79, 0, 7'd0, 5'd0,  1'b0, 8'h00, 8'h00},
		'{ACT_PUT,  8'h51, 8'h2A, 5'd0,  7'd0,   1,  1, 7'd0, 5'd24, 1'b1, 8'h00, 8'h00},
		'{ACT_READ, 8'h00, 8'h00, 5'd23, 7'd79,  1,  1, 7'd0, 5'd24, 1'b0, 8'h51, 8'h2A},
		'{ACT_READ, 8'h00, 8'h00, 5'd23, 7'd0,   1,  1, 7'd0, 5'd24, 1'b0, 8'h5A, 8'h1E},
		// fill with colour zero
		'{ACT_FILL, 8'hFF, 8'h00, 5'd31, 7'd127, 1,  1, 7'd0, 5'd0,  1'b0, 8'h00, 8'h00},
		'{ACT_READ, 8'h00, 8'h00, 5'd24, 7'd79,  1,  1, 7'd0, 5'd0,  1'b0, 8'h20, 8'h00}
	};

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// console behaviour: apply one command to the shadow state, return its result
	function automatic tcw_res_t console_step(input tcw_cmd_t c);
		tcw_res_t r;
		logic [15:0] cell_word;
		r = '0;
		case (c.action)
			ACT_PUT: begin
				if (c.char_code == NEWLINE_CHAR) begin
					cur_col = 0;
					cur_row++;
				end else begin
					shadow_screen[cur_row * COLUMNS + cur_col] = {c.color, c.char_code};
					cur_col++;
					if (cur_col >= COLUMNS) begin
						cur_col = 0;
						cur_row++;
					end
				end
				// scroll up one row, blank bottom row with the fixed colour
				if (cur_row >= ROWS) begin
					for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
						shadow_screen[i] = shadow_screen[i + COLUMNS];
					for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
						shadow_screen[i] = {BLANK_COLOR, BLANK_CHAR};
					cur_row = ROWS - 1;
					r.scrolled = 1'b1;
				end
			end
			ACT_FILL: begin
				for (int i = 0; i < CELL_COUNT; i++)
					shadow_screen[i] = {c.color, BLANK_CHAR};
				cur_col = 0;
				cur_row = 0;
			end
			ACT_READ: begin
				if (c.read_row < ROWS && c.read_col < COLUMNS) begin
					cell_word = shadow_screen[int'(c.read_row) * COLUMNS + int'(c.read_col)];
					r.cell_char  = cell_word[7:0];
					r.cell_color = cell_word[15:8];
				end
			end
			default: ;
		endcase
		r.cursor_col = cur_col[6:0];
		r.cursor_row = cur_row[4:0];
		return r;
	endfunction

	// sender gap, with occasional runs of back-to-back beats
	function automatic int unsigned pick_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			burst_left = $urandom_range(10, 30);
		return $urandom_range(0, 18);
	endfunction

	// drive one command beat, wait for it to be taken; returns the predicted result
	task automatic issue(input tcw_cmd_t c, input int unsigned gap, output tcw_res_t r);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		r = console_step(c);
	endtask

	// hold off until every outstanding result has come back
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		tcw_res_t want;
		if (arst_n && done) begin
			if (pending_res.size() == 0) begin
				$error("result beat with no command outstanding");
				errors++;
			end else begin
				want = pending_res.pop_front();
				if (res.cursor_col !== want.cursor_col) begin
					$error("cursor_col: expected %0d, got %0d", want.cursor_col, res.cursor_col);
					errors++;
				end
				if (res.cursor_row !== want.cursor_row) begin
					$error("cursor_row: expected %0d, got %0d", want.cursor_row, res.cursor_row);
					errors++;
				end
				if (res.scrolled !== want.scrolled) begin
					$error("scrolled: expected %0d, got %0d", want.scrolled, res.scrolled);
					errors++;
				end
				if (res.cell_char !== want.cell_char) begin
					$error("cell_char: expected 0x%02h, got 0x%02h", want.cell_char, res.cell_char);
					errors++;
				end
				if (res.cell_color !== want.cell_color) begin
					$error("cell_color: expected 0x%02h, got 0x%02h", want.cell_color,
						res.cell_color);
					errors++;
				end
			end
		end
	end

	// cycles with no beat in either direction
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// watchdog
	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	// stimulus
	initial begin
		tcw_cmd_t c;
		tcw_res_t r;
		int unsigned pick;
		errors      = 0;
		idle_cycles = 0;
		burst_left  = 0;
		arst_n      = 1'b0;
		start       = 1'b0;
		cmd         = '0;
		for (int i = 0; i < CELL_COUNT; i++)
			shadow_screen[i] = {BLANK_COLOR, BLANK_CHAR};
		cur_col = 0;
		cur_row = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (plan[k]) begin
			for (int n = 0; n < plan[k].reps; n++) begin
				c.action    = plan[k].act;
				c.char_code = plan[k].ch;
				c.color     = plan[k].colr;
				c.read_row  = plan[k].rrow;
				c.read_col  = plan[k].rcol;
				issue(c, pick_gap(), r);
				if (plan[k].typed)
					pending_res.push_back('{plan[k].w_col, plan[k].w_row, plan[k].w_scr,
						plan[k].w_char, plan[k].w_color});
				else
					pending_res.push_back(r);
			end
		end
		drain();

		// random commands: mostly text with plenty of newlines so the screen scrolls often
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			c = tcw_cmd_t'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 57) begin
				c.action = ACT_PUT;
				if ($urandom_range(0, 3) == 0)
					c.char_code = NEWLINE_CHAR;
			end else if (pick < 86) begin
				c.action   = ACT_READ;
				c.read_row = 5'($urandom_range(0, ROWS - 1));
				c.read_col = 7'($urandom_range(0, COLUMNS - 1));
			end else if (pick < 93) begin
				// off-screen read: bad row or bad column
				c.action = ACT_READ;
				if ($urandom_range(0, 1) == 0)
					c.read_row = 5'($urandom_range(ROWS, 31));
				else
					c.read_col = 7'($urandom_range(COLUMNS, 127));
			end else if (pick < 98) begin
				c.action = ACT_NONE;
			end else begin
				c.action = ACT_FILL;
			end
			issue(c, pick_gap(), r);
			pending_res.push_back(r);
			if (k % DRAIN_EVERY == DRAIN_EVERY - 1)
				drain();
		end

		// wait out the tail
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
